// ===== src/tstcw_pkg.sv =====
`timescale 1ns / 1ps
package tstcw_pkg;

	// default sizes
	localparam int MAX_TASKS_DEF    = 16;
	localparam int NUM_CHANNELS_DEF = 32;
	localparam int TIME_BITS_DEF    = 48;

	// fixed port widths
	localparam int ACT_W  = 3;
	localparam int TASK_W = 4;
	localparam int MASK_W = 32;
	localparam int TIME_W = 48;
	localparam int CHAN_W = 5;
	localparam int STAT_W = 2;

	// request codes
	localparam logic [ACT_W-1:0] ACT_START   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_WAIT    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_NOTIFY  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SCHED   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_REQUEUE = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CANCEL  = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ===== src/task_scheduler_timer_channel_wait_top.sv =====
`timescale 1ns / 1ps
// One request is handled at a time; the next request is taken while a result waits at the output.
// Notify and cancel walk the wait and timer lists, schedule walks the timer list, a timed wait shifts
// later timer entries up, and every request ends with a read of the timer head. Each list memory has
// a single read port. Reset (arst_n low) empties all three lists; memories are not cleared.
module task_scheduler_timer_channel_wait_top #(
	parameter int MAX_TASKS    = tstcw_pkg::MAX_TASKS_DEF,
	parameter int NUM_CHANNELS = tstcw_pkg::NUM_CHANNELS_DEF,
	parameter int TIME_BITS    = tstcw_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tstcw_pkg::ACT_W-1:0]     action,
	input  logic [tstcw_pkg::TASK_W-1:0]    task_id,
	input  logic [tstcw_pkg::MASK_W-1:0]    channel_mask,
	input  logic [tstcw_pkg::TIME_W-1:0]    deadline,
	input  logic [tstcw_pkg::CHAN_W-1:0]    channel_id,
	input  logic [tstcw_pkg::TIME_W-1:0]    now_time,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tstcw_pkg::STAT_W-1:0]    status,
	output logic [tstcw_pkg::TASK_W-1:0]    task_out,
	output logic [tstcw_pkg::CHAN_W-1:0]    wake_channel,
	output logic [tstcw_pkg::TIME_W-1:0]    next_deadline,
	output logic                            deadline_valid
);

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int SW = CW + 1;
	localparam int MW = NUM_CHANNELS;
	localparam int TB = TIME_BITS;
	localparam int TW = tstcw_pkg::TASK_W;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_DISP  = 12'b000000000010,
		S_W_RD  = 12'b000000000100,
		S_W_EV  = 12'b000000001000,
		S_T_RD  = 12'b000000010000,
		S_T_EV  = 12'b000000100000,
		S_I_RD  = 12'b000001000000,
		S_I_EV  = 12'b000010000000,
		S_R_RD  = 12'b000100000000,
		S_R_EV  = 12'b001000000000,
		S_H_RD  = 12'b010000000000,
		S_H_EV  = 12'b100000000000
	} state_t;

	// the result hand-off is a state of its own only while the output is occupied
	logic s_out_q, s_out_d;

	state_t st_q, st_d;

	// held request
	logic [tstcw_pkg::ACT_W-1:0]  act_q, act_d;
	logic [TW-1:0]                tsk_q, tsk_d;
	logic [MW-1:0]                mask_q, mask_d;
	logic [TB-1:0]                when_q, when_d;
	logic [tstcw_pkg::CHAN_W-1:0] chan_q, chan_d;
	logic [TB-1:0]                now_q, now_d;

	// list control
	logic [IW-1:0] rdy_head_q, rdy_head_d;
	logic [CW-1:0] rdy_cnt_q, rdy_cnt_d;
	logic [CW-1:0] tmr_cnt_q, tmr_cnt_d;
	logic [CW-1:0] wt_cnt_q, wt_cnt_d;
	logic [CW-1:0] r_q, r_d, w_q, w_d;
	logic          found_q, found_d, expiring_q, expiring_d, hits_q, hits_d;
	logic [TW-1:0] tsel_q, tsel_d;

	// result being built
	logic [tstcw_pkg::STAT_W-1:0] stat_q, stat_d;
	logic [TW-1:0]                tout_q, tout_d;
	logic [tstcw_pkg::CHAN_W-1:0] ach_q, ach_d;
	logic [TB-1:0]                nd_q, nd_d;
	logic                         ndv_q, ndv_d;

	// output register
	logic                         ovld_q;
	logic [tstcw_pkg::STAT_W-1:0] ostat_q;
	logic [TW-1:0]                otask_q;
	logic [tstcw_pkg::CHAN_W-1:0] ochan_q;
	logic [TB-1:0]                ond_q;
	logic                         ondv_q;
	logic                         load_out;

	// memories
	logic [TW-1:0] rmem [MAX_TASKS];
	logic          r_we;
	logic [IW-1:0] r_wa;
	logic [TW-1:0] r_wd;
	logic [TW-1:0] r_rd_q;

	logic [TW-1:0] ttask [MAX_TASKS];
	logic [TB-1:0] ttime [MAX_TASKS];
	logic          t_we;
	logic [IW-1:0] t_wa, t_ra;
	logic [TW-1:0] t_wd_task;
	logic [TB-1:0] t_wd_time;
	logic [TW-1:0] t_rd_task_q;
	logic [TB-1:0] t_rd_time_q;

	logic [TW-1:0] wtask [MAX_TASKS];
	logic [MW-1:0] wmask [MAX_TASKS];
	logic          w_we;
	logic [IW-1:0] w_wa, w_ra;
	logic [TW-1:0] w_wd_task;
	logic [MW-1:0] w_wd_mask;
	logic [TW-1:0] w_rd_task_q;
	logic [MW-1:0] w_rd_mask_q;

	// helpers
	logic [63:0]   mask_ext, when_ext, now_ext, nd_ext;
	logic [SW-1:0] tail_sum, head_inc;
	logic [IW-1:0] tail_idx, head_nxt;
	logic          rdy_full, tmr_full, wt_full, chan_bad, chan_hit;
	logic [MW-1:0] mask_sh;
	logic [CW-1:0] ins_prev;

	assign mask_ext = {32'b0, channel_mask};
	assign when_ext = {16'b0, deadline};
	assign now_ext  = {16'b0, now_time};

	assign rdy_full = (rdy_cnt_q == CW'(MAX_TASKS));
	assign tmr_full = (tmr_cnt_q == CW'(MAX_TASKS));
	assign wt_full  = (wt_cnt_q == CW'(MAX_TASKS));
	assign chan_bad = (7'(chan_q) >= 7'(NUM_CHANNELS));
	assign mask_sh  = w_rd_mask_q >> chan_q;
	assign chan_hit = mask_sh[0];
	assign ins_prev = r_q - CW'(1);

	// ready tail and next head, wrapped at the queue depth
	always_comb begin
		tail_sum = SW'(rdy_head_q) + SW'(rdy_cnt_q);
		if (tail_sum >= SW'(MAX_TASKS)) begin
			tail_sum = tail_sum - SW'(MAX_TASKS);
		end
		tail_idx = tail_sum[IW-1:0];
		head_inc = SW'(rdy_head_q) + SW'(1);
		if (head_inc == SW'(MAX_TASKS)) begin
			head_inc = '0;
		end
		head_nxt = head_inc[IW-1:0];
	end

	assign load_out = s_out_q && (!ovld_q || out_ready);
	assign in_ready = (st_q == S_IDLE) && !s_out_q;

	// sequencer
	always_comb begin
		st_d       = st_q;
		s_out_d    = s_out_q;
		act_d      = act_q;
		tsk_d      = tsk_q;
		mask_d     = mask_q;
		when_d     = when_q;
		chan_d     = chan_q;
		now_d      = now_q;
		rdy_head_d = rdy_head_q;
		rdy_cnt_d  = rdy_cnt_q;
		tmr_cnt_d  = tmr_cnt_q;
		wt_cnt_d   = wt_cnt_q;
		r_d        = r_q;
		w_d        = w_q;
		found_d    = found_q;
		expiring_d = expiring_q;
		hits_d     = hits_q;
		tsel_d     = tsel_q;
		stat_d     = stat_q;
		tout_d     = tout_q;
		ach_d      = ach_q;
		nd_d       = nd_q;
		ndv_d      = ndv_q;

		r_we      = 1'b0;
		r_wa      = tail_idx;
		r_wd      = tsk_q;
		t_we      = 1'b0;
		t_wa      = w_q[IW-1:0];
		t_wd_task = t_rd_task_q;
		t_wd_time = t_rd_time_q;
		t_ra      = r_q[IW-1:0];
		w_we      = 1'b0;
		w_wa      = w_q[IW-1:0];
		w_wd_task = w_rd_task_q;
		w_wd_mask = w_rd_mask_q;
		w_ra      = r_q[IW-1:0];

		if (load_out) begin
			s_out_d = 1'b0;
		end

		case (st_q)
			S_IDLE: begin
				if (in_valid && !s_out_q) begin
					act_d      = action;
					tsk_d      = task_id;
					mask_d     = mask_ext[MW-1:0];
					when_d     = when_ext[TB-1:0];
					chan_d     = channel_id;
					now_d      = now_ext[TB-1:0];
					stat_d     = tstcw_pkg::STAT_OK;
					tout_d     = '0;
					ach_d      = '0;
					found_d    = 1'b0;
					hits_d     = 1'b0;
					expiring_d = 1'b1;
					r_d        = '0;
					w_d        = '0;
					st_d       = S_DISP;
				end
			end
			S_DISP: begin
				st_d = S_H_RD;
				case (act_q)
					tstcw_pkg::ACT_START, tstcw_pkg::ACT_REQUEUE: begin
						if (rdy_full) begin
							stat_d = tstcw_pkg::STAT_FULL;
						end else begin
							r_we      = 1'b1;
							rdy_cnt_d = rdy_cnt_q + CW'(1);
						end
					end
					tstcw_pkg::ACT_WAIT: begin
						if (((mask_q != '0) && wt_full) || ((when_q != '0) && tmr_full)) begin
							stat_d = tstcw_pkg::STAT_FULL;
						end else begin
							if (mask_q != '0) begin
								w_we      = 1'b1;
								w_wa      = wt_cnt_q[IW-1:0];
								w_wd_task = tsk_q;
								w_wd_mask = mask_q;
								wt_cnt_d  = wt_cnt_q + CW'(1);
							end
							if (when_q != '0) begin
								r_d  = tmr_cnt_q;
								st_d = S_I_RD;
							end
						end
					end
					tstcw_pkg::ACT_NOTIFY: begin
						if (chan_bad) begin
							stat_d = tstcw_pkg::STAT_EMPTY;
						end else begin
							st_d = S_W_RD;
						end
					end
					tstcw_pkg::ACT_SCHED: begin
						st_d = S_T_RD;
					end
					tstcw_pkg::ACT_CANCEL: begin
						st_d = S_W_RD;
					end
					default: begin
						st_d = S_H_RD;
					end
				endcase
			end
			// walk the wait list, compacting kept entries
			S_W_RD: begin
				if (r_q == wt_cnt_q) begin
					wt_cnt_d = w_q;
					r_d      = '0;
					w_d      = '0;
					if ((act_q == tstcw_pkg::ACT_NOTIFY) && !found_q) begin
						stat_d = tstcw_pkg::STAT_EMPTY;
						st_d   = S_H_RD;
					end else begin
						st_d = S_T_RD;
					end
				end else begin
					st_d = S_W_EV;
				end
			end
			S_W_EV: begin
				st_d = S_W_RD;
				r_d  = r_q + CW'(1);
				if (act_q == tstcw_pkg::ACT_NOTIFY) begin
					if (!found_q && chan_hit) begin
						if (rdy_full) begin
							// abort: nothing has moved yet
							stat_d = tstcw_pkg::STAT_FULL;
							st_d   = S_H_RD;
						end else begin
							found_d = 1'b1;
							tsel_d  = w_rd_task_q;
						end
					end else begin
						w_we = 1'b1;
						w_d  = w_q + CW'(1);
					end
				end else begin
					if (w_rd_task_q == tsk_q) begin
						hits_d = 1'b1;
					end else begin
						w_we = 1'b1;
						w_d  = w_q + CW'(1);
					end
				end
			end
			// walk the timer list: expire the head run or drop a task
			S_T_RD: begin
				if (r_q == tmr_cnt_q) begin
					tmr_cnt_d = w_q;
					st_d      = S_H_RD;
					case (act_q)
						tstcw_pkg::ACT_NOTIFY: begin
							r_we      = 1'b1;
							r_wd      = tsel_q;
							rdy_cnt_d = rdy_cnt_q + CW'(1);
							tout_d    = tsel_q;
							ach_d     = chan_q;
						end
						tstcw_pkg::ACT_CANCEL: begin
							if (!hits_q) begin
								stat_d = tstcw_pkg::STAT_EMPTY;
							end
						end
						default: begin
							if (rdy_cnt_q == '0) begin
								stat_d = tstcw_pkg::STAT_EMPTY;
							end else begin
								st_d = S_R_RD;
							end
						end
					endcase
				end else begin
					st_d = S_T_EV;
				end
			end
			S_T_EV: begin
				st_d = S_T_RD;
				r_d  = r_q + CW'(1);
				if (act_q == tstcw_pkg::ACT_SCHED) begin
					if (expiring_q && (t_rd_time_q < now_q) && !rdy_full) begin
						r_we      = 1'b1;
						r_wd      = t_rd_task_q;
						rdy_cnt_d = rdy_cnt_q + CW'(1);
					end else begin
						expiring_d = 1'b0;
						t_we       = 1'b1;
						w_d        = w_q + CW'(1);
					end
				end else begin
					if (t_rd_task_q == ((act_q == tstcw_pkg::ACT_NOTIFY) ? tsel_q : tsk_q)) begin
						hits_d = 1'b1;
					end else begin
						t_we = 1'b1;
						w_d  = w_q + CW'(1);
					end
				end
			end
			// sorted insert: shift later deadlines up one place from the tail
			S_I_RD: begin
				t_ra = ins_prev[IW-1:0];
				if (r_q == '0) begin
					t_we      = 1'b1;
					t_wa      = '0;
					t_wd_task = tsk_q;
					t_wd_time = when_q;
					tmr_cnt_d = tmr_cnt_q + CW'(1);
					st_d      = S_H_RD;
				end else begin
					st_d = S_I_EV;
				end
			end
			S_I_EV: begin
				t_we = 1'b1;
				t_wa = r_q[IW-1:0];
				if (when_q < t_rd_time_q) begin
					r_d  = ins_prev;
					st_d = S_I_RD;
				end else begin
					t_wd_task = tsk_q;
					t_wd_time = when_q;
					tmr_cnt_d = tmr_cnt_q + CW'(1);
					st_d      = S_H_RD;
				end
			end
			// pop the ready head
			S_R_RD: begin
				st_d = S_R_EV;
			end
			S_R_EV: begin
				tout_d     = r_rd_q;
				rdy_head_d = head_nxt;
				rdy_cnt_d  = rdy_cnt_q - CW'(1);
				st_d       = S_H_RD;
			end
			// read the timer head for the deadline fields
			S_H_RD: begin
				t_ra = '0;
				st_d = S_H_EV;
			end
			S_H_EV: begin
				ndv_d   = (tmr_cnt_q != '0);
				nd_d    = (tmr_cnt_q != '0) ? t_rd_time_q : '0;
				s_out_d = 1'b1;
				st_d    = S_IDLE;
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			s_out_q    <= 1'b0;
			rdy_head_q <= '0;
			rdy_cnt_q  <= '0;
			tmr_cnt_q  <= '0;
			wt_cnt_q   <= '0;
			ovld_q     <= 1'b0;
		end else begin
			st_q       <= st_d;
			s_out_q    <= s_out_d;
			rdy_head_q <= rdy_head_d;
			rdy_cnt_q  <= rdy_cnt_d;
			tmr_cnt_q  <= tmr_cnt_d;
			wt_cnt_q   <= wt_cnt_d;
			if (load_out) begin
				ovld_q <= 1'b1;
			end else if (out_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		act_q      <= act_d;
		tsk_q      <= tsk_d;
		mask_q     <= mask_d;
		when_q     <= when_d;
		chan_q     <= chan_d;
		now_q      <= now_d;
		r_q        <= r_d;
		w_q        <= w_d;
		found_q    <= found_d;
		expiring_q <= expiring_d;
		hits_q     <= hits_d;
		tsel_q     <= tsel_d;
		stat_q     <= stat_d;
		tout_q     <= tout_d;
		ach_q      <= ach_d;
		nd_q       <= nd_d;
		ndv_q      <= ndv_d;
		if (load_out) begin
			ostat_q <= stat_q;
			otask_q <= tout_q;
			ochan_q <= ach_q;
			ond_q   <= nd_q;
			ondv_q  <= ndv_q;
		end
	end

	// list memories
	always_ff @(posedge clk) begin
		if (r_we) begin
			rmem[r_wa] <= r_wd;
		end
		r_rd_q <= rmem[rdy_head_q];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			ttask[t_wa] <= t_wd_task;
			ttime[t_wa] <= t_wd_time;
		end
		t_rd_task_q <= ttask[t_ra];
		t_rd_time_q <= ttime[t_ra];
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wtask[w_wa] <= w_wd_task;
			wmask[w_wa] <= w_wd_mask;
		end
		w_rd_task_q <= wtask[w_ra];
		w_rd_mask_q <= wmask[w_ra];
	end

	assign nd_ext         = 64'(ond_q);
	assign out_valid      = ovld_q;
	assign status         = ostat_q;
	assign task_out       = otask_q;
	assign wake_channel   = ochan_q;
	assign next_deadline  = nd_ext[tstcw_pkg::TIME_W-1:0];
	assign deadline_valid = ondv_q;

	a_rdy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_cnt_q <= CW'(MAX_TASKS)) else $error("ready count overflow");
	a_lst_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(tmr_cnt_q <= CW'(MAX_TASKS)) && (wt_cnt_q <= CW'(MAX_TASKS)))
		else $error("list count overflow");
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_W_EV || st_q == S_T_EV) |-> (w_q <= r_q))
		else $error("compaction write passed read");
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovld_q) |-> $past(s_out_q)) else $error("result without finished request");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_out_q |-> (st_q == S_IDLE)) else $error("request taken while result pending");

endmodule
